@@ rtl/tctd_pkg.sv @@
// shared types, constants and character helpers for the time display formatter
`timescale 1ns / 1ps

package tctd_pkg;

   // field widths
   localparam int KEY_W      = 8;
   localparam int TICK_W     = 24;
   localparam int CHAR_W     = 8;
   localparam int DIGIT_W    = 4;
   localparam int NUM_DIGITS = 6;
   localparam int SEC_W      = 18;
   localparam int MIN_W      = 13;

   // default depth of the queue between front and back
   localparam int QUEUE_DEPTH_DEFAULT = 2;

   // key codes
   localparam logic [KEY_W-1:0] KEY_MINSEC = 8'd49;
   localparam logic [KEY_W-1:0] KEY_SECS   = 8'd50;
   localparam logic [KEY_W-1:0] KEY_COUNT  = 8'd51;
   localparam logic [KEY_W-1:0] KEY_QUIT   = 8'd113;

   // output characters
   localparam logic [CHAR_W-1:0] CH_CR    = 8'd13;
   localparam logic [CHAR_W-1:0] CH_COLON = 8'd58;
   localparam logic [CHAR_W-1:0] CH_POINT = 8'd46;
   localparam logic [CHAR_W-1:0] CH_ZERO  = 8'd48;

   // reciprocal constants: floor(v / d) == (v * MUL) >> SHIFT over the value range
   localparam int DIV100_MUL   = 21474837;
   localparam int DIV100_SHIFT = 31;
   localparam int DIV60_MUL    = 559241;
   localparam int DIV60_SHIFT  = 25;
   localparam int DIV10_MUL    = 13421773;
   localparam int DIV10_SHIFT  = 27;

   typedef enum logic [1:0] {
      MODE_MINSEC = 2'd0,
      MODE_SECS   = 2'd1,
      MODE_COUNT  = 2'd2
   } mode_type;

   typedef logic [DIGIT_W-1:0] digit_type;
   typedef digit_type [NUM_DIGITS-1:0] digit_array_type;

   // one poll waiting for conversion
   typedef struct packed {
      mode_type          mode;
      logic [TICK_W-1:0] ticks;
   } item_type;

   // one converted display line
   typedef struct packed {
      mode_type        mode;
      digit_array_type digits;
   } line_type;

   function automatic logic [CHAR_W-1:0] digit_char(digit_type d);
      return CH_ZERO + {4'b0000, d};
   endfunction

   // index of the final character of a line
   function automatic logic [2:0] last_index(mode_type mode);
      logic [2:0] idx;
      case (mode)
         MODE_SECS:  idx = 3'd7;
         MODE_COUNT: idx = 3'd6;
         default:    idx = 3'd5;
      endcase
      return idx;
   endfunction

   // character at a position of a line
   function automatic logic [CHAR_W-1:0] char_at(mode_type mode, digit_array_type d,
                                                 logic [2:0] idx);
      logic [CHAR_W-1:0] ch;
      ch = CH_CR;
      case (mode)
         MODE_SECS: begin
            case (idx)
               3'd1:    ch = digit_char(d[5]);
               3'd2:    ch = digit_char(d[4]);
               3'd3:    ch = digit_char(d[3]);
               3'd4:    ch = digit_char(d[2]);
               3'd5:    ch = CH_POINT;
               3'd6:    ch = digit_char(d[1]);
               3'd7:    ch = digit_char(d[0]);
               default: ch = CH_CR;
            endcase
         end
         MODE_COUNT: begin
            case (idx)
               3'd1:    ch = digit_char(d[5]);
               3'd2:    ch = digit_char(d[4]);
               3'd3:    ch = digit_char(d[3]);
               3'd4:    ch = digit_char(d[2]);
               3'd5:    ch = digit_char(d[1]);
               3'd6:    ch = digit_char(d[0]);
               default: ch = CH_CR;
            endcase
         end
         default: begin
            case (idx)
               3'd1:    ch = digit_char(d[3]);
               3'd2:    ch = digit_char(d[2]);
               3'd3:    ch = CH_COLON;
               3'd4:    ch = digit_char(d[1]);
               3'd5:    ch = digit_char(d[0]);
               default: ch = CH_CR;
            endcase
         end
      endcase
      return ch;
   endfunction

endpackage

@@ rtl/tctd_if.sv @@
// poll and character channel interfaces
`timescale 1ns / 1ps

interface tctd_req_if;
   logic                            valid;
   logic                            ready;
   logic                            key_valid;
   logic [tctd_pkg::KEY_W-1:0]      key_byte;
   logic [tctd_pkg::TICK_W-1:0]     tick_count;

   modport source (output valid, key_valid, key_byte, tick_count, input ready);
   modport sink (input valid, key_valid, key_byte, tick_count, output ready);
endinterface

interface tctd_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [tctd_pkg::CHAR_W-1:0]     char_out;
   logic                            last_char;

   modport source (output valid, char_out, last_char, input ready);
   modport sink (input valid, char_out, last_char, output ready);
endinterface

@@ rtl/tctd_front.sv @@
// poll front end: key decode, mode and halt state, queue push
`timescale 1ns / 1ps

module tctd_front (
   input  logic                clock,
   input  logic                reset,
   tctd_req_if.sink            req,
   output logic                push_valid,
   output tctd_pkg::item_type  push_item,
   input  logic                push_ready
);

   tctd_pkg::mode_type mode_ff, mode_in;
   logic               halted_ff, halted_in;
   logic               is_quit;
   logic               xfer;

   // while halted, and for the halt key itself, the poll is swallowed without a push
   assign req.ready  = halted_ff || is_quit || push_ready;
   assign xfer       = req.valid && req.ready;
   assign is_quit    = req.key_valid && (req.key_byte == tctd_pkg::KEY_QUIT);
   assign push_valid = req.valid && !halted_ff && !is_quit;

   // mode keys
   always_comb begin
      mode_in   = mode_ff;
      halted_in = halted_ff;
      if (xfer && !halted_ff && req.key_valid) begin
         unique case (req.key_byte)
            tctd_pkg::KEY_MINSEC: mode_in   = tctd_pkg::MODE_MINSEC;
            tctd_pkg::KEY_SECS:   mode_in   = tctd_pkg::MODE_SECS;
            tctd_pkg::KEY_COUNT:  mode_in   = tctd_pkg::MODE_COUNT;
            tctd_pkg::KEY_QUIT:   halted_in = 1'b1;
            default:              mode_in   = mode_ff;
         endcase
      end
   end

   assign push_item.mode  = mode_in;
   assign push_item.ticks = req.tick_count;

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= tctd_pkg::MODE_MINSEC;
         halted_ff <= 1'b0;
      end else begin
         mode_ff   <= mode_in;
         halted_ff <= halted_in;
      end
   end

`ifndef SYNTHESIS
   a_no_push_halted: assert property (@(posedge clock) disable iff (reset)
      halted_ff |-> !push_valid)
      else $error("poll pushed after halt");
   a_halt_sticky: assert property (@(posedge clock) disable iff (reset)
      halted_ff |=> halted_ff)
      else $error("halt state cleared without reset");
`endif

endmodule

@@ rtl/tctd_queue.sv @@
// small fifo of polls between front and back
`timescale 1ns / 1ps

module tctd_queue #(
   parameter int DEPTH = tctd_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   input  tctd_pkg::item_type  push_item,
   output logic                push_ready,
   output logic                pop_valid,
   output tctd_pkg::item_type  pop_item,
   input  logic                pop_ready
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   tctd_pkg::item_type entry_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               push, pop;

   assign push_ready = count_ff != CNT_W'(DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_item   = entry_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   // pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("queue fill beyond depth");
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("queue fill not advanced on push");
`endif

endmodule

@@ rtl/tctd_conv.sv @@
// back end converter: tick count to decimal digits, one digit per cycle
`timescale 1ns / 1ps

module tctd_conv (
   input  logic                clock,
   input  logic                reset,
   input  logic                item_valid,
   input  tctd_pkg::item_type  item,
   output logic                item_ready,
   output logic                line_valid,
   output tctd_pkg::line_type  line,
   input  logic                line_ready
);

   localparam int TW    = tctd_pkg::TICK_W;
   localparam int SW    = tctd_pkg::SEC_W;
   localparam int MW    = tctd_pkg::MIN_W;
   localparam int P100W = TW + 25;
   localparam int P60W  = SW + 20;
   localparam int P10W  = 2 * TW;
   localparam int QW    = P10W - tctd_pkg::DIV10_SHIFT;
   localparam int CW    = $clog2(tctd_pkg::NUM_DIGITS);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV60,
      ST_DIGIT,
      ST_DONE
   } state_type;

   state_type          state_ff, state_in;
   tctd_pkg::line_type line_ff, line_in;
   logic [TW-1:0]      n_ff, n_in;
   logic [CW-1:0]      cnt_ff, cnt_in;

   logic [P100W-1:0]   prod100;
   logic [SW-1:0]      sec_total;
   logic [P60W-1:0]    prod60;
   logic [MW-1:0]      mins;
   logic [TW-1:0]      mmss;
   logic [P10W-1:0]    prod10;
   logic [QW-1:0]      quot;
   logic [TW-1:0]      rem;
   logic [CW-1:0]      last_digit;
   logic               take_out;

   // whole seconds of the incoming count
   assign prod100   = {25'd0, item.ticks} * P100W'(tctd_pkg::DIV100_MUL);
   assign sec_total = prod100[tctd_pkg::DIV100_SHIFT +: SW];

   // minutes, then mins * 100 + secs as seconds + 40 * minutes
   assign prod60 = {20'd0, n_ff[SW-1:0]} * P60W'(tctd_pkg::DIV60_MUL);
   assign mins   = prod60[tctd_pkg::DIV60_SHIFT +: MW];
   assign mmss   = {6'd0, n_ff[SW-1:0]} + {6'd0, mins, 5'd0} + {8'd0, mins, 3'd0};

   // divide by ten with the remainder as the next digit
   assign prod10 = {{TW{1'b0}}, n_ff} * P10W'(tctd_pkg::DIV10_MUL);
   assign quot   = prod10[tctd_pkg::DIV10_SHIFT +: QW];
   assign rem    = n_ff - {quot, 3'd0} - {2'd0, quot, 1'd0};

   assign last_digit = (line_ff.mode == tctd_pkg::MODE_SECS ||
                        line_ff.mode == tctd_pkg::MODE_COUNT) ? CW'(5) : CW'(3);

   assign line_valid = state_ff == ST_DONE;
   assign line       = line_ff;
   assign take_out   = line_valid && line_ready;
   assign item_ready = (state_ff == ST_IDLE) || take_out;

   // sequencer
   always_comb begin
      state_in = state_ff;
      line_in  = line_ff;
      n_in     = n_ff;
      cnt_in   = cnt_ff;
      unique case (state_ff)
         ST_IDLE, ST_DONE: begin
            if (state_ff == ST_DONE && take_out) begin
               state_in = ST_IDLE;
            end
            if (item_valid && item_ready) begin
               line_in.mode = item.mode;
               cnt_in       = '0;
               if (item.mode == tctd_pkg::MODE_SECS || item.mode == tctd_pkg::MODE_COUNT) begin
                  n_in     = item.ticks;
                  state_in = ST_DIGIT;
               end else begin
                  n_in     = {6'd0, sec_total};
                  state_in = ST_DIV60;
               end
            end
         end
         ST_DIV60: begin
            n_in     = mmss;
            cnt_in   = '0;
            state_in = ST_DIGIT;
         end
         ST_DIGIT: begin
            line_in.digits[cnt_ff] = rem[tctd_pkg::DIGIT_W-1:0];
            n_in   = {{(TW - QW){1'b0}}, quot};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == last_digit) begin
               state_in = ST_DONE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      line_ff <= line_in;
      n_ff    <= n_in;
      cnt_ff  <= cnt_in;
   end

endmodule

@@ rtl/tctd_emit.sv @@
// back end emitter: serializes one display line into characters
`timescale 1ns / 1ps

module tctd_emit (
   input  logic                clock,
   input  logic                reset,
   input  logic                line_valid,
   input  tctd_pkg::line_type  line,
   output logic                line_ready,
   tctd_rsp_if.source          rsp
);

   tctd_pkg::line_type          line_ff;
   logic                        busy_ff;
   logic [2:0]                  idx_ff;
   logic                        out_valid_ff;
   logic [tctd_pkg::CHAR_W-1:0] out_char_ff;
   logic                        out_last_ff;

   logic [2:0] last_idx;
   logic       last_now;
   logic       out_free;
   logic       send;
   logic       finish;
   logic       load;

   assign last_idx   = tctd_pkg::last_index(line_ff.mode);
   assign last_now   = idx_ff == last_idx;
   assign out_free   = !out_valid_ff || rsp.ready;
   assign send       = busy_ff && out_free;
   assign finish     = send && last_now;
   assign line_ready = !busy_ff || finish;
   assign load       = line_valid && line_ready;

   assign rsp.valid     = out_valid_ff;
   assign rsp.char_out  = out_char_ff;
   assign rsp.last_char = out_last_ff;

   // line walk and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (load) begin
            busy_ff <= 1'b1;
         end else if (finish) begin
            busy_ff <= 1'b0;
         end
         if (send) begin
            out_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
      if (load) begin
         line_ff <= line;
         idx_ff  <= '0;
      end else if (send) begin
         idx_ff <= idx_ff + 1'b1;
      end
      if (send) begin
         out_char_ff <= tctd_pkg::char_at(line_ff.mode, line_ff.digits, idx_ff);
         out_last_ff <= last_now;
      end
   end

`ifndef SYNTHESIS
   a_idx_bound: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (idx_ff <= last_idx))
      else $error("character index past end of line");
`endif

endmodule

@@ rtl/tick_count_time_display_formatter.sv @@
// top level of the stopwatch time display formatter
`timescale 1ns / 1ps

// Each accepted poll updates the display mode from its key ('1' mm:ss, '2' seconds,
// '3' raw count, 'q' halts all later output) and queues the tick count. The back end
// turns the count into decimal digits at one digit per cycle, overlapped with output,
// and sends the line one character per cycle unless the receiver holds ready low, the
// final one marked with last_char. Sustained rate is set by that one-character-per-cycle
// output register. Polls are taken at once while the queue has room; polls that emit
// nothing (the halt key, or anything after it) are taken at once in any case.
module tick_count_time_display_formatter #(
   parameter int QUEUE_DEPTH = tctd_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   tctd_req_if.sink    req_bus,
   tctd_rsp_if.source  rsp_bus
);

   logic               push_valid, push_ready;
   tctd_pkg::item_type push_item;
   logic               pop_valid, pop_ready;
   tctd_pkg::item_type pop_item;
   logic               line_valid, line_ready;
   tctd_pkg::line_type line;

   // key decode and mode state
   tctd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_bus),
      .push_valid (push_valid),
      .push_item  (push_item),
      .push_ready (push_ready)
   );

   // decoupling queue
   tctd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_item  (push_item),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_item   (pop_item),
      .pop_ready  (pop_ready)
   );

   // digit conversion
   tctd_conv u_conv (
      .clock      (clock),
      .reset      (reset),
      .item_valid (pop_valid),
      .item       (pop_item),
      .item_ready (pop_ready),
      .line_valid (line_valid),
      .line       (line),
      .line_ready (line_ready)
   );

   // character output
   tctd_emit u_emit (
      .clock      (clock),
      .reset      (reset),
      .line_valid (line_valid),
      .line       (line),
      .line_ready (line_ready),
      .rsp        (rsp_bus)
   );

endmodule

@@ bench/testbench.sv @@
// self-checking bench for the stopwatch time display formatter
`timescale 1ns / 1ps

module testbench;

   localparam int HALF_PERIOD  = 4;
   localparam int RESET_CYCLES = 10;
   localparam int IDLE_PCT     = 12;
   localparam int RANDOM_POLLS = 160;
   localparam int QUIET_FIRST  = 50;
   localparam int QUIET_LAST   = 90;
   localparam int DRAIN_LIMIT  = 5000;
   localparam int SETTLE       = 40;
   localparam int NUM_LEAD     = 18;
   localparam int NUM_ROWS     = 22;
   localparam int MAX_LINE     = 8;

   // how a poll's line is checked
   typedef enum logic [1:0] {
      CHECK_PREDICT,
      CHECK_LINE,
      CHECK_SILENT
   } check_kind_type;

   typedef struct {
      check_kind_type              kind;
      logic                        kv;
      logic [tctd_pkg::KEY_W-1:0]  kb;
      logic [tctd_pkg::TICK_W-1:0] tc;
      string                       text;
   } poll_row_type;

   typedef struct packed {
      logic [tctd_pkg::CHAR_W-1:0] ch;
      logic                        last;
   } shown_char_type;

   // directed polls; typed text follows the carriage return
   poll_row_type poll_rows [NUM_ROWS] = '{
      '{CHECK_LINE,    1'b0, 8'h00,               24'd0,        "00:00"},
      '{CHECK_LINE,    1'b0, tctd_pkg::KEY_SECS,   24'd599999,   "99:59"},
      '{CHECK_LINE,    1'b1, 8'hFF,               24'd16777215, "96:12"},
      '{CHECK_LINE,    1'b1, tctd_pkg::KEY_SECS,   24'd0,        "0000.00"},
      '{CHECK_LINE,    1'b1, 8'h00,               24'd16777215, "7772.15"},
      '{CHECK_LINE,    1'b0, tctd_pkg::KEY_MINSEC, 24'd999999,   "9999.99"},
      '{CHECK_LINE,    1'b1, tctd_pkg::KEY_COUNT,  24'd0,        "000000"},
      '{CHECK_LINE,    1'b1, tctd_pkg::KEY_COUNT,  24'd16777215, "777215"},
      '{CHECK_LINE,    1'b0, tctd_pkg::KEY_QUIT,   24'd999999,   "999999"},
      '{CHECK_LINE,    1'b1, 8'h30,               24'd1000000,  "000000"},
      '{CHECK_LINE,    1'b1, tctd_pkg::KEY_MINSEC, 24'd600000,   "00:00"},
      '{CHECK_LINE,    1'b1, tctd_pkg::KEY_MINSEC, 24'd6000,     "01:00"},
      '{CHECK_LINE,    1'b1, 8'h34,               24'd5999,     "00:59"},
      '{CHECK_PREDICT, 1'b1, tctd_pkg::KEY_SECS,   24'h555555,   ""},
      '{CHECK_PREDICT, 1'b1, tctd_pkg::KEY_COUNT,  24'hAAAAAA,   ""},
      '{CHECK_PREDICT, 1'b1, tctd_pkg::KEY_MINSEC, 24'h123456,   ""},
      '{CHECK_PREDICT, 1'b0, 8'h55,               24'h800000,   ""},
      '{CHECK_PREDICT, 1'b1, 8'hAA,               24'h7FFFFF,   ""},
      // halt and the polls after it, sent at the very end
      '{CHECK_SILENT,  1'b1, tctd_pkg::KEY_QUIT,   24'd0,        ""},
      '{CHECK_SILENT,  1'b1, tctd_pkg::KEY_MINSEC, 24'd100,      ""},
      '{CHECK_SILENT,  1'b1, tctd_pkg::KEY_COUNT,  24'd16777215, ""},
      '{CHECK_SILENT,  1'b0, 8'h00,               24'd0,        ""}
   };

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic no_idle = 1'b0;

   tctd_req_if req_bus ();
   tctd_rsp_if rsp_bus ();

   tick_count_time_display_formatter i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   always #HALF_PERIOD clock = ~clock;

   // predictor state, starts as after reset
   tctd_pkg::mode_type shown_mode = tctd_pkg::MODE_MINSEC;
   logic               halted = 1'b0;

   // check kind of the poll currently on the request channel
   check_kind_type row_kind = CHECK_PREDICT;
   string          row_text = "";

   shown_char_type expected_chars [$];
   int fail_count = 0;
   int polls_taken = 0;
   int chars_checked = 0;
   int lines_checked = 0;

   function automatic logic [tctd_pkg::CHAR_W-1:0] dec_digit(input int unsigned v,
                                                             input int unsigned div);
      return tctd_pkg::CH_ZERO + tctd_pkg::CHAR_W'((v / div) % 10);
   endfunction

   // display line of one poll; updates mode and halt state
   function automatic int predict_line(input logic kv, input logic [tctd_pkg::KEY_W-1:0] kb,
                                       input logic [tctd_pkg::TICK_W-1:0] tc,
                                       output logic [tctd_pkg::CHAR_W-1:0] chars [MAX_LINE]);
      int unsigned ticks;
      int unsigned secs;
      int unsigned mins;
      int n;
      ticks = tc;
      n = 0;
      for (int i = 0; i < MAX_LINE; i++) chars[i] = tctd_pkg::CH_CR;
      if (halted) return 0;
      if (kv) begin
         case (kb)
            tctd_pkg::KEY_MINSEC: shown_mode = tctd_pkg::MODE_MINSEC;
            tctd_pkg::KEY_SECS:   shown_mode = tctd_pkg::MODE_SECS;
            tctd_pkg::KEY_COUNT:  shown_mode = tctd_pkg::MODE_COUNT;
            tctd_pkg::KEY_QUIT: begin
               halted = 1'b1;
               return 0;
            end
            default: ;
         endcase
      end
      case (shown_mode)
         tctd_pkg::MODE_SECS: begin
            secs = ticks / 100;
            chars[1] = dec_digit(secs, 1000);
            chars[2] = dec_digit(secs, 100);
            chars[3] = dec_digit(secs, 10);
            chars[4] = dec_digit(secs, 1);
            chars[5] = tctd_pkg::CH_POINT;
            chars[6] = dec_digit(ticks % 100, 10);
            chars[7] = dec_digit(ticks % 100, 1);
            n = 8;
         end
         tctd_pkg::MODE_COUNT: begin
            chars[1] = dec_digit(ticks, 100000);
            chars[2] = dec_digit(ticks, 10000);
            chars[3] = dec_digit(ticks, 1000);
            chars[4] = dec_digit(ticks, 100);
            chars[5] = dec_digit(ticks, 10);
            chars[6] = dec_digit(ticks, 1);
            n = 7;
         end
         default: begin
            mins = ticks / 6000;
            secs = (ticks % 6000) / 100;
            chars[1] = dec_digit(mins, 10);
            chars[2] = dec_digit(mins, 1);
            chars[3] = tctd_pkg::CH_COLON;
            chars[4] = dec_digit(secs, 10);
            chars[5] = dec_digit(secs, 1);
            n = 6;
         end
      endcase
      return n;
   endfunction

   // one poll transfer, with random idle cycles ahead of it
   task automatic send_poll(input check_kind_type kind, input logic kv,
                            input logic [tctd_pkg::KEY_W-1:0] kb,
                            input logic [tctd_pkg::TICK_W-1:0] tc,
                            input string text);
      while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.key_valid  <= kv;
      req_bus.key_byte   <= kb;
      req_bus.tick_count <= tc;
      row_kind           <= kind;
      row_text           <= text;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
   endtask

   // tick counts near digit and minute boundaries as well as spread out
   function automatic logic [tctd_pkg::TICK_W-1:0] pick_ticks();
      int unsigned v;
      case ($urandom_range(3))
         0: v = $urandom() & 32'h00FF_FFFF;
         1: v = $urandom_range(999999);
         2: begin
            v = $urandom_range(2796) * 6000;
            case ($urandom_range(3))
               0: v = v + 5999;
               1: v = v + 99;
               2: v = v + 100;
               default: ;
            endcase
            if (v > 32'h00FF_FFFF) v = 32'h00FF_FFFF;
         end
         default: v = $urandom_range(16777215, 16000000);
      endcase
      return tctd_pkg::TICK_W'(v);
   endfunction

   // result side stalls at random, except in the quiet stretch
   always @(posedge clock) begin
      rsp_bus.ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
   end

   // predict on each poll transfer, check each character transfer
   always @(posedge clock) begin
      logic [tctd_pkg::CHAR_W-1:0] line [MAX_LINE];
      int n;
      shown_char_type want;
      if (!reset && req_bus.valid && req_bus.ready) begin
         n = predict_line(req_bus.key_valid, req_bus.key_byte, req_bus.tick_count, line);
         if (row_kind == CHECK_LINE) begin
            n = row_text.len() + 1;
            line[0] = tctd_pkg::CH_CR;
            for (int i = 1; i < n; i++) line[i] = row_text[i-1];
         end else if (row_kind == CHECK_SILENT) begin
            n = 0;
         end
         for (int i = 0; i < n; i++) expected_chars.push_back('{line[i], i == n - 1});
         polls_taken++;
      end
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_chars.size() == 0) begin
            $display("%0t: unexpected character, expected none, actual %0d last %0b",
                     $time, rsp_bus.char_out, rsp_bus.last_char);
            fail_count++;
         end else begin
            want = expected_chars.pop_front();
            if (rsp_bus.char_out !== want.ch) begin
               $display("%0t: char_out mismatch, expected %0d, actual %0d",
                        $time, want.ch, rsp_bus.char_out);
               fail_count++;
            end
            if (rsp_bus.last_char !== want.last) begin
               $display("%0t: last_char mismatch, expected %0b, actual %0b",
                        $time, want.last, rsp_bus.last_char);
               fail_count++;
            end
            chars_checked++;
            if (want.last) lines_checked++;
         end
      end
   end

   // stimulus: directed rows, random polls, then the halt rows
   initial begin
      logic                       kv;
      logic [tctd_pkg::KEY_W-1:0] kb;
      int                         waited;
      req_bus.valid      = 1'b0;
      req_bus.key_valid  = 1'b0;
      req_bus.key_byte   = '0;
      req_bus.tick_count = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int r = 0; r < NUM_LEAD; r++) begin
         send_poll(poll_rows[r].kind, poll_rows[r].kv, poll_rows[r].kb, poll_rows[r].tc,
                   poll_rows[r].text);
      end

      for (int k = 0; k < RANDOM_POLLS; k++) begin
         if (k == QUIET_FIRST) no_idle <= 1'b1;
         if (k == QUIET_LAST) no_idle <= 1'b0;
         kv = 1'($urandom_range(1));
         if ($urandom_range(99) < 45) begin
            case ($urandom_range(2))
               0: kb = tctd_pkg::KEY_MINSEC;
               1: kb = tctd_pkg::KEY_SECS;
               default: kb = tctd_pkg::KEY_COUNT;
            endcase
         end else begin
            kb = tctd_pkg::KEY_W'($urandom_range(255));
            // the halt key is kept for the end of the run
            if (kb == tctd_pkg::KEY_QUIT) kb = tctd_pkg::KEY_QUIT ^ 8'h01;
         end
         send_poll(CHECK_PREDICT, kv, kb, pick_ticks(), "");
      end

      for (int r = NUM_LEAD; r < NUM_ROWS; r++) begin
         send_poll(poll_rows[r].kind, poll_rows[r].kv, poll_rows[r].kb, poll_rows[r].tc,
                   poll_rows[r].text);
      end
      req_bus.valid <= 1'b0;

      // drain the outstanding characters
      waited = 0;
      while (expected_chars.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      if (expected_chars.size() != 0) begin
         $display("%0t: timeout, %0d characters still expected", $time,
                  expected_chars.size());
         $display("testbench failed");
         $finish;
      end else begin
         repeat (SETTLE) @(posedge clock);
         $display("covered %0d polls over all three display modes, ending with the halt key",
                  polls_taken);
         $display("checked %0d characters in %0d lines, %0d mismatches",
                  chars_checked, lines_checked, fail_count);
         if (fail_count == 0) begin
            $display("testbench passed");
         end else begin
            $display("testbench failed");
         end
         $finish;
      end
   end

   // overall time limit
   initial begin
      #2000000;
      $display("%0t: run time limit reached", $time);
      $display("testbench failed");
      $finish;
   end

endmodule
